[hdl/tsq_pkg.sv]
// shared types, constants and codes for the two-stack queue
package tsq_pkg;

   localparam int DATA_W        = 32;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 8;

   // operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_POP_RD,
      S_WAIT_OUT,
      S_WAIT_IN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                op_load;
      logic                push;
      logic                res_set;
      logic [STATUS_W-1:0] res_code;
      logic                move_rd;
      logic                move_wr;
      logic                pop_rd;
      logic                peek_in_rd;
      logic                res_from_in;
      logic                res_from_out;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] op_mode;
      logic              in_full;
      logic              in_empty;
      logic              out_empty;
      logic              rsp_free;
   } stat_type;

endpackage

[hdl/tsq_req_if.sv]
// request channel: operation and word to enqueue
interface tsq_req_if;
   logic                               valid;
   logic                               ready;
   logic [tsq_pkg::MODE_W-1:0]         mode;
   logic signed [tsq_pkg::DATA_W-1:0]  data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink   (input valid, input mode, input data_in, output ready);
endinterface

[hdl/tsq_rsp_if.sv]
// response channel: returned word and status
interface tsq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tsq_pkg::DATA_W-1:0]  data_out;
   logic [tsq_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output data_out, output status, input ready);
   modport sink   (input valid, input data_out, input status, output ready);
endinterface

[hdl/tsq_ram.sv]
// generic single-write, single-read ram with registered read data
module tsq_ram #(
   parameter int WIDTH = tsq_pkg::DATA_W,
   parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tsq_datapath.sv]
// datapath: stack memories, stack pointers, result and response registers
module tsq_datapath #(
   parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tsq_pkg::cmd_type                   cmd,
   output tsq_pkg::stat_type                  stat,
   input  logic [tsq_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [tsq_pkg::DATA_W-1:0]  req_data_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tsq_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [tsq_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] in_count_ff, in_count_in;
   logic [CW-1:0] out_count_ff, out_count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [tsq_pkg::MODE_W-1:0]         op_mode_ff;
   logic signed [tsq_pkg::DATA_W-1:0]  op_data_ff;
   logic signed [tsq_pkg::DATA_W-1:0]  res_data_ff, res_data_in;
   logic [tsq_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic signed [tsq_pkg::DATA_W-1:0]  rsp_data_ff;
   logic [tsq_pkg::STATUS_W-1:0]       rsp_status_ff;

   logic [CW-1:0]                in_top, out_top;
   logic [AW-1:0]                in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
   logic [tsq_pkg::DATA_W-1:0]   in_rd_data, out_rd_data;

   assign in_top      = in_count_ff - CW'(1);
   assign out_top     = out_count_ff - CW'(1);
   assign in_wr_addr  = in_count_ff[AW-1:0];
   assign in_rd_addr  = cmd.peek_in_rd ? AW'(0) : in_top[AW-1:0];
   assign out_wr_addr = out_count_ff[AW-1:0];
   assign out_rd_addr = out_top[AW-1:0];

   tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(DEPTH)) u_in_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (in_wr_addr),
      .wr_data (op_data_ff),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   // transfer writes the word just read from the input stack
   tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (cmd.move_wr),
      .wr_addr (out_wr_addr),
      .wr_data (in_rd_data),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   always_comb begin
      in_count_in = in_count_ff;
      if (cmd.push) begin
         in_count_in = in_count_ff + CW'(1);
      end else if (cmd.move_rd) begin
         in_count_in = in_top;
      end
   end

   always_comb begin
      out_count_in = out_count_ff;
      if (cmd.move_wr) begin
         out_count_in = out_count_ff + CW'(1);
      end else if (cmd.pop_rd) begin
         out_count_in = out_top;
      end
   end

   always_comb begin
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      if (cmd.res_set) begin
         res_data_in   = '0;
         res_status_in = cmd.res_code;
      end else if (cmd.res_from_out) begin
         res_data_in   = out_rd_data;
         res_status_in = tsq_pkg::ST_OK;
      end else if (cmd.res_from_in) begin
         res_data_in   = in_rd_data;
         res_status_in = tsq_pkg::ST_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         op_mode_ff <= req_mode;
         op_data_ff <= req_data_in;
      end
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      if (cmd.rsp_load) begin
         rsp_data_ff   <= res_data_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign stat.op_mode   = op_mode_ff;
   assign stat.in_full   = (in_count_ff == CW'(DEPTH));
   assign stat.in_empty  = (in_count_ff == '0);
   assign stat.out_empty = (out_count_ff == '0);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

[hdl/tsq_ctrl.sv]
// controller: sequences each operation and the stack-to-stack transfer
module tsq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tsq_pkg::stat_type  stat,
   output tsq_pkg::cmd_type   cmd
);

   tsq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = tsq_pkg::S_DECODE;
            end
         end
         tsq_pkg::S_DECODE: begin
            case (stat.op_mode)
               tsq_pkg::MODE_DEQ: begin
                  if (!stat.out_empty) begin
                     state_in = tsq_pkg::S_POP_RD;
                  end else if (!stat.in_empty) begin
                     state_in = tsq_pkg::S_MOVE_RD;
                  end else begin
                     state_in = tsq_pkg::S_DONE;
                  end
               end
               tsq_pkg::MODE_PEEK: begin
                  if (!stat.out_empty) begin
                     state_in = tsq_pkg::S_WAIT_OUT;
                  end else if (!stat.in_empty) begin
                     state_in = tsq_pkg::S_WAIT_IN;
                  end else begin
                     state_in = tsq_pkg::S_DONE;
                  end
               end
               default: begin
                  state_in = tsq_pkg::S_DONE;
               end
            endcase
         end
         tsq_pkg::S_MOVE_RD: begin
            state_in = tsq_pkg::S_MOVE_WR;
         end
         tsq_pkg::S_MOVE_WR: begin
            // input count already dropped by the read step
            if (stat.in_empty) begin
               state_in = tsq_pkg::S_POP_RD;
            end else begin
               state_in = tsq_pkg::S_MOVE_RD;
            end
         end
         tsq_pkg::S_POP_RD: begin
            state_in = tsq_pkg::S_WAIT_OUT;
         end
         tsq_pkg::S_WAIT_OUT: begin
            state_in = tsq_pkg::S_DONE;
         end
         tsq_pkg::S_WAIT_IN: begin
            state_in = tsq_pkg::S_DONE;
         end
         tsq_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               state_in = tsq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tsq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tsq_pkg::S_IDLE: begin
            // no transaction is taken while reset is held
            req_ready   = !reset;
            cmd.op_load = req_valid && !reset;
         end
         tsq_pkg::S_DECODE: begin
            case (stat.op_mode)
               tsq_pkg::MODE_ENQ: begin
                  cmd.res_set = 1'b1;
                  if (stat.in_full) begin
                     cmd.res_code = tsq_pkg::ST_FULL;
                  end else begin
                     cmd.push     = 1'b1;
                     cmd.res_code = tsq_pkg::ST_OK;
                  end
               end
               tsq_pkg::MODE_DEQ: begin
                  if (stat.out_empty && stat.in_empty) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = tsq_pkg::ST_EMPTY;
                  end
               end
               tsq_pkg::MODE_PEEK: begin
                  // front is the output top, else the input stack bottom
                  if (stat.out_empty && stat.in_empty) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = tsq_pkg::ST_EMPTY;
                  end else if (stat.out_empty) begin
                     cmd.peek_in_rd = 1'b1;
                  end
               end
               default: begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = tsq_pkg::ST_OK;
               end
            endcase
         end
         tsq_pkg::S_MOVE_RD: begin
            cmd.move_rd = 1'b1;
         end
         tsq_pkg::S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
         end
         tsq_pkg::S_POP_RD: begin
            cmd.pop_rd = 1'b1;
         end
         tsq_pkg::S_WAIT_OUT: begin
            cmd.res_from_out = 1'b1;
         end
         tsq_pkg::S_WAIT_IN: begin
            cmd.res_from_in = 1'b1;
         end
         tsq_pkg::S_DONE: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hdl/two_stack_fifo_queue.sv]
// top level of the two-stack queue: controller, datapath and channel hookup
//
// Request channel (req_chan) carries an operation code and a 32-bit word:
// enqueue pushes the word, dequeue removes the oldest word, peek returns the
// oldest word without removing it. Every transaction gives exactly one
// response on rsp_chan with the word (zero when none) and a status of ok,
// full (word dropped) or empty. Up to 2*DEPTH-1 words are held.
// One operation is in flight at a time. A dequeue that finds the output stack
// empty first moves every input-stack word across, then pops the output top.
// The transfer moves one word per read/write pair on the registered-read
// stack memories. The response becomes valid in the same cycle that the
// block returns to idle and can accept the next request.
// The response register lets a new request be accepted while the previous
// response waits; a stalled receiver holds the response steady and the
// block finishes the next operation up to its response, then waits.
// Synchronous reset empties both stacks and drops any pending response;
// the memories are not cleared.
module two_stack_fifo_queue #(
   parameter int DEPTH = tsq_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tsq_req_if.sink    req_chan,
   tsq_rsp_if.source  rsp_chan
);

   tsq_pkg::cmd_type  cmd;
   tsq_pkg::stat_type stat;

   tsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsq_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_mode     (req_chan.mode),
      .req_data_in  (req_chan.data_in),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_data_out (rsp_chan.data_out),
      .rsp_status   (rsp_chan.status)
   );

endmodule

[hdl/tsq_checker.sv]
// port-level checks for the two-stack queue, bound to the top level
module tsq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tsq_pkg::DATA_W-1:0]    rsp_data_out,
   input logic [tsq_pkg::STATUS_W-1:0]  rsp_status
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
      else $error("response changed while stalled");

   // full and empty responses carry no word
   a_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tsq_pkg::ST_OK |-> rsp_data_out == '0)
      else $error("nonzero word with full or empty status");

   // one operation at a time
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind two_stack_fifo_queue tsq_checker u_tsq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_data_out (rsp_chan.data_out),
   .rsp_status   (rsp_chan.status)
);
